/* rtl/sgs_pkg.sv */
// Package for the scatter-gather get splitter.
// Holds the transfer structs, command and status codes, and the shared enums.
// No dependencies.
package sgs_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int unsigned CMD_W = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FIELD_ADDR_W = 48;
  localparam int unsigned FIELD_LEN_W = 32;
  localparam int unsigned COUNT_W = 16;

  // Defaults handed to the top-level parameters.
  localparam int unsigned DEF_MAX_SEGMENTS = 16;
  localparam int unsigned DEF_ADDR_WIDTH = 48;
  localparam int unsigned DEF_LEN_WIDTH = 32;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [COUNT_W-1:0] INIT_CREDITS_RESET = 16'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_SRC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_DST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RETURN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_ISSUED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_STALLED = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 3'd4;

  // One command transfer.
  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [FIELD_ADDR_W-1:0] segment_address;
    logic [FIELD_LEN_W-1:0]  segment_length;
  } item_t;

  // One result transfer.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [FIELD_ADDR_W-1:0] source_address;
    logic [FIELD_ADDR_W-1:0] dest_address;
    logic [FIELD_LEN_W-1:0]  get_length;
    logic [COUNT_W-1:0]      outstanding;
    logic [COUNT_W-1:0]      credits_left;
  } result_t;

  // Classified operation passed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_LOAD_SRC,
    OP_LOAD_DST,
    OP_ADVANCE,
    OP_RETURN,
    OP_CLEAR,
    OP_NOP
  } op_kind_e;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic     valid;
    op_kind_e kind;
  } op_ctrl_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_ISSUE
  } back_state_e;

endpackage

/* rtl/sgs_front.sv */
// Front part of the splitter: accepts commands, classifies them and queues them.
// Depends on sgs_pkg.
module sgs_front #(
  parameter int unsigned ADDR_WIDTH = sgs_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned LEN_WIDTH = sgs_pkg::DEF_LEN_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sgs_pkg::item_t       item,
  output logic                 busy,
  output sgs_pkg::op_ctrl_t    op,
  output logic [ADDR_WIDTH-1:0] op_addr,
  output logic [LEN_WIDTH-1:0]  op_len,
  input  logic                 pop
);
  import sgs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  op_kind_e              q_kind [QUEUE_DEPTH];
  logic [ADDR_WIDTH-1:0] q_addr [QUEUE_DEPTH];
  logic [LEN_WIDTH-1:0]  q_len  [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [FILL_W-1:0]     fill;
  logic                  push;
  op_kind_e              kind;

  // Classify the incoming command.
  always_comb begin
    unique case (item.command)
      CMD_LOAD_SRC: kind = OP_LOAD_SRC;
      CMD_LOAD_DST: kind = OP_LOAD_DST;
      CMD_ADVANCE:  kind = OP_ADVANCE;
      CMD_RETURN:   kind = OP_RETURN;
      CMD_CLEAR:    kind = OP_CLEAR;
      default:      kind = OP_NOP;
    endcase
  end

  assign busy = (fill == FILL_W'(QUEUE_DEPTH));
  assign push = start && !busy;

  // Queue storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_kind[wr_ptr] <= kind;
      q_addr[wr_ptr] <= ADDR_WIDTH'(item.segment_address);
      q_len[wr_ptr]  <= LEN_WIDTH'(item.segment_length);
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Head of the queue.
  assign op.valid = (fill != '0);
  assign op.kind  = q_kind[rd_ptr];
  assign op_addr  = q_addr[rd_ptr];
  assign op_len   = q_len[rd_ptr];

endmodule

/* rtl/sgs_back.sv */
// Back part of the splitter: segment stores, list walk, credit accounting and results.
// Depends on sgs_pkg.
module sgs_back #(
  parameter int unsigned MAX_SEGMENTS = sgs_pkg::DEF_MAX_SEGMENTS,
  parameter int unsigned ADDR_WIDTH = sgs_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned LEN_WIDTH = sgs_pkg::DEF_LEN_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sgs_pkg::op_ctrl_t           op,
  input  logic [ADDR_WIDTH-1:0]       op_addr,
  input  logic [LEN_WIDTH-1:0]        op_len,
  output logic                        pop,
  input  logic [sgs_pkg::COUNT_W-1:0] initial_credits,
  output logic                        result_valid,
  output sgs_pkg::result_t            result
);
  import sgs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SUM_W = (ADDR_WIDTH > LEN_WIDTH) ? ADDR_WIDTH : LEN_WIDTH;

  // Segment stores.
  logic [ADDR_WIDTH-1:0] src_addr_mem [MAX_SEGMENTS];
  logic [LEN_WIDTH-1:0]  src_len_mem  [MAX_SEGMENTS];
  logic [ADDR_WIDTH-1:0] dst_addr_mem [MAX_SEGMENTS];
  logic [LEN_WIDTH-1:0]  dst_len_mem  [MAX_SEGMENTS];
  logic [ADDR_WIDTH-1:0] src_addr_rd;
  logic [LEN_WIDTH-1:0]  src_len_rd;
  logic [ADDR_WIDTH-1:0] dst_addr_rd;
  logic [LEN_WIDTH-1:0]  dst_len_rd;
  logic                  src_we;
  logic                  dst_we;

  back_state_e          state, state_next;
  logic [CNT_W-1:0]     src_count, src_count_next;
  logic [CNT_W-1:0]     dst_count, dst_count_next;
  logic [CNT_W-1:0]     src_index, src_index_next;
  logic [CNT_W-1:0]     dst_index, dst_index_next;
  logic [LEN_WIDTH-1:0] src_offset, src_offset_next;
  logic [LEN_WIDTH-1:0] dst_offset, dst_offset_next;
  logic [COUNT_W-1:0]   credit_count, credit_count_next;
  logic [COUNT_W-1:0]   pending_gets, pending_gets_next;
  logic [LEN_WIDTH-1:0] s_rem, s_rem_next;
  logic [LEN_WIDTH-1:0] d_rem, d_rem_next;
  result_t              result_next;
  logic                 result_valid_next;

  logic                 s_end, d_end, s_skip, d_skip;
  logic [LEN_WIDTH-1:0] glen;
  logic [SUM_W-1:0]     sa_sum, da_sum;

  // Stores are written at the fill count and read at the current index.
  always_ff @(posedge clk) begin
    if (src_we) begin
      src_addr_mem[src_count[IDX_W-1:0]] <= op_addr;
      src_len_mem[src_count[IDX_W-1:0]]  <= op_len;
    end
    if (dst_we) begin
      dst_addr_mem[dst_count[IDX_W-1:0]] <= op_addr;
      dst_len_mem[dst_count[IDX_W-1:0]]  <= op_len;
    end
    src_addr_rd <= src_addr_mem[src_index[IDX_W-1:0]];
    src_len_rd  <= src_len_mem[src_index[IDX_W-1:0]];
    dst_addr_rd <= dst_addr_mem[dst_index[IDX_W-1:0]];
    dst_len_rd  <= dst_len_mem[dst_index[IDX_W-1:0]];
  end

  // List end and skip tests on the segment read for the current index.
  assign s_end  = (src_index >= src_count);
  assign d_end  = (dst_index >= dst_count);
  assign s_skip = !s_end && (src_offset >= src_len_rd);
  assign d_skip = !d_end && (dst_offset >= dst_len_rd);

  // Get length and addresses, used in the issue state.
  assign glen   = (s_rem < d_rem) ? s_rem : d_rem;
  assign sa_sum = SUM_W'(src_addr_rd) + SUM_W'(src_offset);
  assign da_sum = SUM_W'(dst_addr_rd) + SUM_W'(dst_offset);

  // Sequencer state and list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      src_count    <= '0;
      dst_count    <= '0;
      src_index    <= '0;
      dst_index    <= '0;
      src_offset   <= '0;
      dst_offset   <= '0;
      credit_count <= INIT_CREDITS_RESET;
      pending_gets <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      src_count    <= src_count_next;
      dst_count    <= dst_count_next;
      src_index    <= src_index_next;
      dst_index    <= dst_index_next;
      src_offset   <= src_offset_next;
      dst_offset   <= dst_offset_next;
      credit_count <= credit_count_next;
      pending_gets <= pending_gets_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    s_rem  <= s_rem_next;
    d_rem  <= d_rem_next;
    result <= result_next;
  end

  // Next state and outputs.
  always_comb begin
    state_next        = state;
    src_count_next    = src_count;
    dst_count_next    = dst_count;
    src_index_next    = src_index;
    dst_index_next    = dst_index;
    src_offset_next   = src_offset;
    dst_offset_next   = dst_offset;
    credit_count_next = credit_count;
    pending_gets_next = pending_gets;
    s_rem_next        = s_rem;
    d_rem_next        = d_rem;
    result_next       = '0;
    result_valid_next = 1'b0;
    src_we            = 1'b0;
    dst_we            = 1'b0;
    pop               = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (op.valid) begin
          pop = 1'b1;
          result_next.status = STATUS_ACCEPTED;
          result_valid_next  = 1'b1;
          case (op.kind)
            OP_LOAD_SRC: begin
              if (src_count < CNT_W'(MAX_SEGMENTS)) begin
                src_we         = 1'b1;
                src_count_next = src_count + 1'b1;
              end
            end
            OP_LOAD_DST: begin
              if (dst_count < CNT_W'(MAX_SEGMENTS)) begin
                dst_we         = 1'b1;
                dst_count_next = dst_count + 1'b1;
              end
            end
            OP_ADVANCE: begin
              // The result comes from the walk that follows.
              result_valid_next = 1'b0;
              state_next        = ST_CHECK;
            end
            OP_RETURN: begin
              if (credit_count != COUNT_MAX) begin
                credit_count_next = credit_count + 1'b1;
              end
              if (pending_gets != '0) begin
                pending_gets_next = pending_gets - 1'b1;
              end
            end
            OP_CLEAR: begin
              src_count_next    = '0;
              dst_count_next    = '0;
              src_index_next    = '0;
              dst_index_next    = '0;
              src_offset_next   = '0;
              dst_offset_next   = '0;
              credit_count_next = initial_credits;
              pending_gets_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        // Wait for the store read at the new index.
        state_next = ST_CHECK;
      end

      ST_CHECK: begin
        if (s_skip || d_skip) begin
          // Step past exhausted or empty segments, then read again.
          if (s_skip) begin
            src_index_next  = src_index + 1'b1;
            src_offset_next = '0;
          end
          if (d_skip) begin
            dst_index_next  = dst_index + 1'b1;
            dst_offset_next = '0;
          end
          state_next = ST_READ;
        end else if (s_end || d_end || (credit_count == '0)) begin
          if (s_end && d_end) begin
            result_next.status = STATUS_COMPLETE;
          end else if (s_end || d_end) begin
            result_next.status = STATUS_MISMATCH;
          end else begin
            result_next.status = STATUS_STALLED;
          end
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          s_rem_next = src_len_rd - src_offset;
          d_rem_next = dst_len_rd - dst_offset;
          state_next = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        // Issue the get of the shorter remainder.
        result_next.status         = STATUS_ISSUED;
        result_next.source_address = FIELD_ADDR_W'(sa_sum[ADDR_WIDTH-1:0]);
        result_next.dest_address   = FIELD_ADDR_W'(da_sum[ADDR_WIDTH-1:0]);
        result_next.get_length     = FIELD_LEN_W'(glen);
        src_offset_next            = src_offset + glen;
        dst_offset_next            = dst_offset + glen;
        credit_count_next          = credit_count - 1'b1;
        if (pending_gets != COUNT_MAX) begin
          pending_gets_next = pending_gets + 1'b1;
        end
        result_valid_next = 1'b1;
        state_next        = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Counters as they stand after the step.
    result_next.outstanding  = pending_gets_next;
    result_next.credits_left = credit_count_next;
  end

endmodule

/* rtl/scatter_gather_get_splitter.sv */
// Scatter-gather get splitter: pairs source and destination segments into gets.
// A load, return, clear or unused code is queued, then popped and answered with an accepted
// result; an advance walks the lists and ends in one issued, complete, mismatch or stalled
// result, after any skip steps (one step passes a spent segment on either list or both).
// Throughput: one command a cycle, advances excepted; a full two-entry queue sets busy;
// results cannot be stalled. Synchronous reset empties the lists and queue, sets 16 credits.
module scatter_gather_get_splitter #(
  parameter int unsigned MAX_SEGMENTS = sgs_pkg::DEF_MAX_SEGMENTS,
  parameter int unsigned ADDR_WIDTH = sgs_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned LEN_WIDTH = sgs_pkg::DEF_LEN_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  sgs_pkg::item_t                 item,
  output logic                           result_valid,
  output sgs_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sgs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sgs_pkg::*;

  logic [COUNT_W-1:0]    initial_credits;
  logic                  cfg_write;
  logic                  reg_sel;
  op_ctrl_t              op;
  logic [ADDR_WIDTH-1:0] op_addr;
  logic [LEN_WIDTH-1:0]  op_len;
  logic                  pop;

  // Configuration register: a single word at byte address zero.
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[CFG_ADDR_W-1] == 1'b0);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_sel ? CFG_DATA_W'(initial_credits) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_credits <= INIT_CREDITS_RESET;
    end else if (cfg_write && reg_sel) begin
      initial_credits <= pwdata[COUNT_W-1:0];
    end
  end

  // Command intake and queue.
  sgs_front #(
    .ADDR_WIDTH(ADDR_WIDTH),
    .LEN_WIDTH (LEN_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .op     (op),
    .op_addr(op_addr),
    .op_len (op_len),
    .pop    (pop)
  );

  // List walk and get issue.
  sgs_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .LEN_WIDTH   (LEN_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .op_addr        (op_addr),
    .op_len         (op_len),
    .pop            (pop),
    .initial_credits(initial_credits),
    .result_valid   (result_valid),
    .result         (result)
  );

endmodule
